FILE: rtl/sha1_stream_hash_unit_assert.svh
// Assertion macros shared by the SHA-1 stream hash checker.
// Holds macros only; include with the bare file name.
`ifndef SHA1_STREAM_HASH_UNIT_ASSERT_SVH
`define SHA1_STREAM_HASH_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`endif

FILE: rtl/sha_pkg.sv
// Package for the SHA-1 stream hash unit: function codes, constants, round helpers.
// No dependencies.
package sha_pkg;
  typedef enum logic [1:0] {
    FUNC_ABSORB = 2'd0,
    FUNC_DIGEST = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam int unsigned QDEPTH  = 2;

  typedef struct packed {
    func_e      func;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20)      k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else                k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20)      f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else                f = b ^ c ^ d;
    return f;
  endfunction
endpackage

FILE: rtl/sha_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module sha_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/sha_front.sv
// Front end: accepts items, drops unused codes, queues commands for the core.
// Depends on sha_pkg.
module sha_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    func_i,
  input  logic [7:0]    data_byte_i,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i,
  output sha_pkg::cmd_t cmd_o
);
  sha_pkg::cmd_t q_q [sha_pkg::QDEPTH];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push;

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && (func_i != sha_pkg::FUNC_NONE);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= '{func: sha_pkg::func_e'(func_i), data: data_byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (cmd_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end
endmodule

FILE: rtl/sha_core.sv
// Back end: block buffer, 80-round compression, padding and digest output.
// Depends on sha_pkg and sha_ram.
module sha_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  sha_pkg::cmd_t cmd_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   digest_word_o,
  output logic [2:0]    word_index_o,
  output logic          last_word_o
);
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD  = 8'b0000_0010,
    S_ROUND = 8'b0000_0100,
    S_ADD   = 8'b0000_1000,
    S_NEXT  = 8'b0001_0000,
    S_EMIT  = 8'b0010_0000,
    S_PREP  = 8'b0100_0000,
    S_WAIT  = 8'b1000_0000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  h_q [5];
  logic [31:0]  hw_q [5];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  w_q [16];
  logic [5:0]   fill_q;
  logic [63:0]  len_q;
  logic [6:0]   cnt_q;
  logic         dig_q;   // compressing a padded copy
  logic         second_q; // padding needs a second block
  logic [2:0]   idx_q;
  logic         ov_q;
  logic [31:0]  ow_q;
  logic [2:0]   oi_q;
  logic [5:0]   raddr;
  logic [7:0]   rdata;
  logic         we;
  logic [7:0]   pbyte;
  logic [5:0]   bpos_q;
  logic [31:0]  wnew, t;
  logic [6:0]   r;

  sha_ram #(.Width(8), .Depth(64)) u_buf (
    .clk_i, .we_i(we), .waddr_i(fill_q), .wdata_i(cmd_i.data),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign we        = (state_q == S_IDLE) && cmd_valid_i && (cmd_i.func == sha_pkg::FUNC_ABSORB);
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;
  // Load runs cnt 0..64: the address is issued in the cycle before its data arrives.
  assign raddr = cnt_q[5:0];
  assign r     = cnt_q;

  // Padded byte at position bpos_q (data read in the previous cycle).
  always_comb begin
    logic [5:0] n;
    n = fill_q;
    if (!dig_q)                             pbyte = rdata;
    else if (!second_q && bpos_q >= 6'd56)  pbyte = len_q[8'd63 - {2'b0, bpos_q[2:0], 3'b0} -: 8];
    else if (second_q && bpos_q < n)        pbyte = rdata;
    else if (second_q && bpos_q == n)       pbyte = 8'h80;
    else if (!second_q && bpos_q < n && n <= 6'd55)  pbyte = rdata;
    else if (!second_q && bpos_q == n && n <= 6'd55) pbyte = 8'h80;
    else                                    pbyte = 8'h00;
  end

  always_comb begin
    wnew = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wnew = {wnew[30:0], wnew[31]};
    t = {a_q[26:0], a_q[31:27]} + sha_pkg::round_f(r, b_q, c_q, d_q) + e_q
        + sha_pkg::round_k(r) + w_q[0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_valid_i) begin
        if (cmd_i.func == sha_pkg::FUNC_ABSORB && fill_q == 6'd63) state_d = S_PREP;
        else if (cmd_i.func == sha_pkg::FUNC_DIGEST) state_d = S_PREP;
      end
      S_PREP:  state_d = S_LOAD;
      S_LOAD:  if (cnt_q == 7'd64) state_d = S_ROUND;
      S_ROUND: if (cnt_q == 7'd79) state_d = S_ADD;
      S_ADD:   state_d = S_NEXT;
      S_NEXT:  state_d = (dig_q && second_q) ? S_PREP : (dig_q ? S_EMIT : S_IDLE);
      S_EMIT:  state_d = S_WAIT;
      S_WAIT:  if (!ov_q || !out_stall_i) state_d = (idx_q == 3'd5) ? S_IDLE : S_EMIT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      dig_q    <= 1'b0;
      second_q <= 1'b0;
      idx_q    <= '0;
      ov_q     <= 1'b0;
      h_q[0] <= sha_pkg::H0_INIT; h_q[1] <= sha_pkg::H1_INIT; h_q[2] <= sha_pkg::H2_INIT;
      h_q[3] <= sha_pkg::H3_INIT; h_q[4] <= sha_pkg::H4_INIT;
    end else begin
      state_q <= state_d;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_valid_i) begin
          unique case (cmd_i.func)
            sha_pkg::FUNC_ABSORB: begin
              fill_q <= fill_q + 6'd1;
              len_q  <= len_q + 64'd8;
              dig_q  <= 1'b0;
              second_q <= 1'b0;
              for (int i = 0; i < 5; i++) hw_q[i] <= h_q[i];
            end
            sha_pkg::FUNC_DIGEST: begin
              dig_q <= 1'b1;
              second_q <= (fill_q > 6'd55);
              for (int i = 0; i < 5; i++) hw_q[i] <= h_q[i];
            end
            sha_pkg::FUNC_CLEAR: begin
              fill_q <= '0;
              len_q  <= '0;
              h_q[0] <= sha_pkg::H0_INIT; h_q[1] <= sha_pkg::H1_INIT;
              h_q[2] <= sha_pkg::H2_INIT; h_q[3] <= sha_pkg::H3_INIT;
              h_q[4] <= sha_pkg::H4_INIT;
            end
            default: ;
          endcase
        end
        S_PREP: begin
          cnt_q <= 7'd1;
          bpos_q <= '0;
          a_q <= hw_q[0]; b_q <= hw_q[1]; c_q <= hw_q[2]; d_q <= hw_q[3]; e_q <= hw_q[4];
        end
        S_LOAD: begin
          // shift bytes into the last word; advance the window once a word is complete
          w_q[15] <= {w_q[15][23:0], pbyte};
          if (bpos_q[1:0] == 2'd0 && bpos_q != 6'd0) begin
            for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          end
          bpos_q <= bpos_q + 6'd1;
          cnt_q  <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= wnew;
          e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]}; b_q <= a_q; a_q <= t;
          cnt_q <= cnt_q + 7'd1;
        end
        S_ADD: begin
          hw_q[0] <= hw_q[0] + a_q; hw_q[1] <= hw_q[1] + b_q; hw_q[2] <= hw_q[2] + c_q;
          hw_q[3] <= hw_q[3] + d_q; hw_q[4] <= hw_q[4] + e_q;
          cnt_q <= '0;
        end
        S_NEXT: begin
          if (!dig_q) begin
            for (int i = 0; i < 5; i++) h_q[i] <= hw_q[i];
            fill_q <= '0;
          end
          second_q <= 1'b0;
          idx_q <= '0;
        end
        S_EMIT: begin
          ov_q <= 1'b1;
          ow_q <= hw_q[idx_q];
          oi_q <= idx_q;
          idx_q <= idx_q + 3'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = ov_q;
  assign digest_word_o = ow_q;
  assign word_index_o  = oi_q;
  assign last_word_o   = (oi_q == 3'd4);
endmodule

FILE: rtl/sha1_stream_hash_unit.sv
// Channel | dir | signals
// in      | in  | in_valid_i, in_stall_o, func_i, data_byte_i
// out     | out | out_valid_o, out_stall_i, digest_word_o, word_index_o, last_word_o
// An item is queued at accept and popped by the core once the core is idle; clear and
// absorb, but for a block's 64th byte, leave the core idle, so an idle core takes one
// item per cycle. The 64th byte holds the core through prep, load, 80 rounds, add, commit.
// Digest takes one or two such passes, then five words, each through emit and wait states.
// Reset async active low; in_stall_o rises with two items queued; words wait on out stall.
module sha1_stream_hash_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  logic          cmd_valid, cmd_pop;
  sha_pkg::cmd_t cmd;

  sha_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .data_byte_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o
  );
endmodule

FILE: rtl/sha_checker.sv
// Port-level checker for the SHA-1 stream hash unit, bound to the top level.
// Depends on sha1_stream_hash_unit_assert.svh.
`include "sha1_stream_hash_unit_assert.svh"
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  `SHA_ASSERT_IMP(a_last, clk_i, rst_ni, out_valid_o, last_word_o == (word_index_o == 3'd4), "last flag")
  `SHA_ASSERT_IMP(a_idx, clk_i, rst_ni, out_valid_o, word_index_o <= 3'd4, "index range")
  `SHA_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(digest_word_o), "held word")
endmodule

bind sha1_stream_hash_unit sha_checker u_chk (.*);
